[src/pli_pkg.sv]
// Shared types and constants for the positional list engine.
package pli_pkg;

    // Default number of list entries.
    localparam int CAPACITY = 128;

    // Number of cell read lanes that one first-level gather register combines.
    localparam int GROUP_SIZE = 16;

    // Operation codes carried by a request.
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_UPDATE = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    // One request on the input channel.
    typedef struct packed {
        op_t                operation;
        logic [7:0]         position;
        logic signed [31:0] value;
    } cmd_t;

    // One result on the output channel.
    typedef struct packed {
        status_t            status;
        logic signed [31:0] read_value;
        logic [7:0]         entry_count;
    } res_t;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic               apply;
        op_t                op;
        logic [7:0]         pos;
        logic signed [31:0] val;
    } cell_ctl_t;

endpackage

[src/positional_list_insert_delete.sv]
// Top level of the positional list engine: request checks, cell row and result register.
// Path from an accepted request to its result: request registers, cell row, first-level
// gather registers, result register. No new request is taken until the previous result is
// in the result register; read data passes a two-level OR tree, registered after level one.
// A new request is taken while the previous result still waits to be taken.
// Reset clears the entry count and all control; entries are undefined until written.
module positional_list_insert_delete #(
    parameter int CAPACITY = pli_pkg::CAPACITY
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  pli_pkg::cmd_t  cmd,
    output logic           res_valid,
    input  logic           res_stall,
    output pli_pkg::res_t  res
);

    localparam logic [7:0] CapC = 8'(CAPACITY);

    // Control state.
    logic [7:0] count_reg;
    logic [7:0] count_next;
    logic       s1_reg;
    logic       s2_reg;
    logic       s3_reg;
    logic       s3_next;
    logic       res_valid_reg;
    logic       res_valid_next;

    // Request payload held while the request is in flight.
    pli_pkg::op_t       op_reg;
    logic [7:0]         pos_reg;
    logic signed [31:0] val_reg;
    logic               ok_reg;
    pli_pkg::status_t   status_reg;
    logic [7:0]         cnt_out_reg;
    pli_pkg::res_t      res_reg;

    logic               busy;
    logic               accept;
    logic               res_load;
    pli_pkg::status_t   status_c;
    pli_pkg::cell_ctl_t ctl;
    logic signed [31:0] gathered;

    logic [CAPACITY-1:0][31:0] entries;
    logic [CAPACITY-1:0][31:0] lanes;

    assign busy      = s1_reg | s2_reg | s3_reg;
    assign cmd_stall = busy;
    assign accept    = cmd_valid && !busy;
    assign res_load  = s3_reg && (!res_valid_reg || !res_stall);

    // Request checks against the current count; full and empty come first.
    always_comb
    begin
        status_c   = pli_pkg::ST_OK;
        count_next = count_reg;
        case (cmd.operation)
            pli_pkg::OP_INSERT:
            begin
                if (count_reg >= CapC)
                    status_c = pli_pkg::ST_FULL;
                else if (cmd.position > count_reg)
                    status_c = pli_pkg::ST_BADPOS;
                else
                    count_next = count_reg + 8'd1;
            end
            pli_pkg::OP_DELETE:
            begin
                if (count_reg == 8'd0)
                    status_c = pli_pkg::ST_EMPTY;
                else if (cmd.position >= count_reg)
                    status_c = pli_pkg::ST_BADPOS;
                else
                    count_next = count_reg - 8'd1;
            end
            pli_pkg::OP_UPDATE:
            begin
                if (cmd.position >= count_reg)
                    status_c = pli_pkg::ST_BADPOS;
            end
            pli_pkg::OP_READ:
            begin
                if (count_reg == 8'd0)
                    status_c = pli_pkg::ST_EMPTY;
                else if (cmd.position >= count_reg)
                    status_c = pli_pkg::ST_BADPOS;
            end
            default:
            begin
            end
        endcase
    end

    // Stage progress; the last stage waits while the result register is full and stalled.
    always_comb
    begin
        s3_next = s3_reg ? !res_load : s2_reg;
        if (res_load)
            res_valid_next = 1'b1;
        else if (res_valid_reg && !res_stall)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            s1_reg        <= 1'b0;
            s2_reg        <= 1'b0;
            s3_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                count_reg <= count_next;
            s1_reg        <= accept;
            s2_reg        <= s1_reg;
            s3_reg        <= s3_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Request payload capture.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= cmd.operation;
            pos_reg     <= cmd.position;
            val_reg     <= cmd.value;
            ok_reg      <= (status_c == pli_pkg::ST_OK);
            status_reg  <= status_c;
            cnt_out_reg <= count_next;
        end
    end

    // Broadcast to the cells in the cycle after acceptance.
    assign ctl.apply = s1_reg && ok_reg;
    assign ctl.op    = op_reg;
    assign ctl.pos   = pos_reg;
    assign ctl.val   = val_reg;

    // Row of cells, each linked to its two neighbors.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [31:0] left_c;
        logic signed [31:0] right_c;
        logic signed [31:0] entry_c;
        logic signed [31:0] rd_c;

        if (i == 0)
        begin : g_first
            assign left_c = '0;
        end
        else
        begin : g_mid_l
            assign left_c = signed'(entries[i-1]);
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_c = '0;
        end
        else
        begin : g_mid_r
            assign right_c = signed'(entries[i+1]);
        end

        pli_cell #(
            .IDX (i)
        ) u_cell (
            .clk   (clk),
            .ctl   (ctl),
            .left  (left_c),
            .right (right_c),
            .entry (entry_c),
            .rd    (rd_c)
        );

        assign entries[i] = unsigned'(entry_c);
        assign lanes[i]   = unsigned'(rd_c);
    end

    pli_gather #(
        .CAPACITY (CAPACITY)
    ) u_gather (
        .clk   (clk),
        .load  (s2_reg),
        .lanes (lanes),
        .value (gathered)
    );

    // Result register.
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg.status      <= status_reg;
            res_reg.read_value  <= gathered;
            res_reg.entry_count <= cnt_out_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

[src/pli_cell.sv]
// One list cell: holds a single entry and shifts with its neighbors.
module pli_cell #(
    parameter int IDX = 0
) (
    input  logic                      clk,
    input  pli_pkg::cell_ctl_t        ctl,
    input  logic signed [31:0]        left,
    input  logic signed [31:0]        right,
    output logic signed [31:0]        entry,
    output logic signed [31:0]        rd
);

    localparam logic [7:0] IdxC = 8'(IDX);

    logic signed [31:0] entry_reg;
    logic signed [31:0] entry_next;
    logic signed [31:0] rd_reg;
    logic signed [31:0] rd_next;
    logic               hit;

    assign hit = (ctl.pos == IdxC);

    // Next entry: take from the lower neighbor on insert, the upper one on
    // delete, or the request value at the target position.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.apply)
        begin
            case (ctl.op)
                pli_pkg::OP_INSERT:
                begin
                    if (ctl.pos < IdxC)
                        entry_next = left;
                    else if (hit)
                        entry_next = ctl.val;
                end
                pli_pkg::OP_DELETE:
                begin
                    if (IdxC >= ctl.pos)
                        entry_next = right;
                end
                pli_pkg::OP_UPDATE:
                begin
                    if (hit)
                        entry_next = ctl.val;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Read lane: the entry when this cell is the read target, otherwise zero.
    always_comb
    begin
        rd_next = '0;
        if (ctl.apply && (ctl.op == pli_pkg::OP_READ) && hit)
            rd_next = entry_reg;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        rd_reg    <= rd_next;
    end

    assign entry = entry_reg;
    assign rd    = rd_reg;

endmodule

[src/pli_gather.sv]
// Registered OR tree that collects the one active read lane of the cells.
module pli_gather #(
    parameter int CAPACITY = pli_pkg::CAPACITY
) (
    input  logic                             clk,
    input  logic                             load,
    input  logic [CAPACITY-1:0][31:0]        lanes,
    output logic signed [31:0]               value
);

    localparam int GroupSize = pli_pkg::GROUP_SIZE;
    localparam int NumGroups = (CAPACITY + GroupSize - 1) / GroupSize;

    logic [NumGroups-1:0][31:0] group_reg;
    logic [NumGroups-1:0][31:0] group_next;
    logic [31:0]                acc;

    // First level: OR each group of lanes.
    always_comb
    begin
        for (int g = 0; g < NumGroups; g++)
        begin
            group_next[g] = '0;
            for (int k = 0; k < GroupSize; k++)
            begin
                if (g * GroupSize + k < CAPACITY)
                    group_next[g] = group_next[g] | lanes[g * GroupSize + k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            group_reg <= group_next;
    end

    // Second level: OR the group registers.
    always_comb
    begin
        acc = '0;
        for (int g = 0; g < NumGroups; g++)
            acc = acc | group_reg[g];
    end

    assign value = signed'(acc);

endmodule

[dv/pli_checker.sv]
// Result checker for the positional list engine: predicts every result and compares it.
module pli_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  logic           cmd_stall,
    input  pli_pkg::cmd_t  cmd,
    input  logic           res_valid,
    input  logic           res_stall,
    input  pli_pkg::res_t  res,
    output int             error_count,
    output int             pending_count,
    output int             list_len
);
    import pli_pkg::*;

    // Predicted list contents and number of valid entries.
    logic signed [31:0] list_mem [0:CAPACITY-1];
    logic [7:0]         entry_total;

    // Results still owed by the block, oldest first.
    res_t expected_results [$];

    // Apply one request to the predicted list and return the result it must produce.
    function automatic res_t apply_list_op(input cmd_t req);
        res_t outcome;
        int   idx;
        outcome.status     = ST_OK;
        outcome.read_value = '0;
        case (req.operation)
            OP_INSERT:
            begin
                if (entry_total >= CAPACITY)
                    outcome.status = ST_FULL;
                else if (req.position > entry_total)
                    outcome.status = ST_BADPOS;
                else
                begin
                    for (idx = int'(entry_total); idx > req.position; idx--)
                        list_mem[idx] = list_mem[idx-1];
                    list_mem[req.position] = req.value;
                    entry_total++;
                end
            end
            OP_DELETE:
            begin
                if (entry_total == 0)
                    outcome.status = ST_EMPTY;
                else if (req.position >= entry_total)
                    outcome.status = ST_BADPOS;
                else
                begin
                    for (idx = int'(req.position); idx + 1 < entry_total; idx++)
                        list_mem[idx] = list_mem[idx+1];
                    entry_total--;
                end
            end
            OP_UPDATE:
            begin
                if (req.position >= entry_total)
                    outcome.status = ST_BADPOS;
                else
                    list_mem[req.position] = req.value;
            end
            default:
            begin
                if (entry_total == 0)
                    outcome.status = ST_EMPTY;
                else if (req.position >= entry_total)
                    outcome.status = ST_BADPOS;
                else
                    outcome.read_value = list_mem[req.position];
            end
        endcase
        outcome.entry_count = entry_total;
        return outcome;
    endfunction

    // Compare accepted results first, then record the prediction for an accepted request.
    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        res_t want;
        int   bad;
        if (!rst_n)
        begin
            expected_results.delete();
            entry_total = '0;
            error_count   <= 0;
            pending_count <= 0;
            list_len      <= 0;
        end
        else
        begin
            bad = 0;
            if (res_valid && !res_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: status %0d read_value %0d entry_count %0d",
                           res.status, res.read_value, res.entry_count);
                    bad++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (res.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, res.status);
                        bad++;
                    end
                    if (res.read_value !== want.read_value)
                    begin
                        $error("read_value: expected %0d, actual %0d",
                               want.read_value, res.read_value);
                        bad++;
                    end
                    if (res.entry_count !== want.entry_count)
                    begin
                        $error("entry_count: expected %0d, actual %0d",
                               want.entry_count, res.entry_count);
                        bad++;
                    end
                end
            end
            if (cmd_valid && !cmd_stall)
                expected_results.push_back(apply_list_op(cmd));
            error_count   <= error_count + bad;
            pending_count <= expected_results.size();
            list_len      <= int'(entry_total);
        end
    end

endmodule

[dv/positional_list_insert_delete_tb.sv]
// Testbench top for the positional list engine: clock, reset, requests, result stalls, verdict.
module positional_list_insert_delete_tb;
    import pli_pkg::*;

    localparam int RANDOM_TOTAL    = 1330;
    localparam int REQUEST_TOTAL   = 1350;
    localparam int QUIET_TAIL      = 150;
    localparam int SEGMENT_LEN     = 270;
    localparam int HOLD_OFF_START  = 400;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_POINT     = 800;
    localparam int TAIL_CYCLES     = 20;
    localparam int WATCHDOG_LIMIT  = 2000;

    // Mix of operations used while steering the list length.
    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_EVEN
    } mix_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    cmd_t cmd;
    logic res_valid;
    logic res_stall;
    res_t res;

    int   error_count;
    int   pending_count;
    int   list_len;
    int   request_index;
    logic hold_off;

    always #4 clk = ~clk;

    positional_list_insert_delete uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    pli_checker list_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_stall     (cmd_stall),
        .cmd           (cmd),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .res           (res),
        .error_count   (error_count),
        .pending_count (pending_count),
        .list_len      (list_len)
    );

    function automatic cmd_t make_cmd(input op_t op, input int pos, input int val);
        cmd_t req;
        req.operation = op;
        req.position  = pos[7:0];
        req.value     = val;
        return req;
    endfunction

    // Random request; positions mostly fall inside the current list, values often at extremes.
    function automatic cmd_t random_request(input mix_t mix);
        cmd_t req;
        int   roll;
        int   extreme;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_GROW:
                req.operation = (roll < 75) ? OP_INSERT : (roll < 85) ? OP_DELETE :
                                (roll < 92) ? OP_UPDATE : OP_READ;
            MIX_SHRINK:
                req.operation = (roll < 10) ? OP_INSERT : (roll < 75) ? OP_DELETE :
                                (roll < 87) ? OP_UPDATE : OP_READ;
            default:
                req.operation = (roll < 30) ? OP_INSERT : (roll < 55) ? OP_DELETE :
                                (roll < 75) ? OP_UPDATE : OP_READ;
        endcase
        if ($urandom_range(0, 99) < 15)
            req.position = 8'($urandom_range(0, 255));
        else if (req.operation == OP_INSERT)
            req.position = 8'($urandom_range(0, list_len));
        else
            req.position = (list_len == 0) ? 8'd0 : 8'($urandom_range(0, list_len - 1));
        if ($urandom_range(0, 7) == 0)
        begin
            extreme = $urandom_range(0, 4);
            req.value = (extreme == 0) ? 32'sh8000_0000 : (extreme == 1) ? 32'sh7fff_ffff :
                        (extreme == 2) ? 32'sd0 : (extreme == 3) ? -32'sd1 : 32'sd1;
        end
        else
            req.value = $urandom;
        return req;
    endfunction

    // Offer one request and hold it until the block takes it.
    task automatic send_request(input cmd_t req);
        cmd_valid <= 1'b1;
        cmd       <= req;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        request_index <= request_index + 1;
    endtask

    task automatic idle_sender(input int cycles);
        cmd_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Stop offering requests until every predicted result has come back.
    task automatic wait_for_drain();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    // Request side: reset, directed cases, then random traffic that swings the list
    // between empty and full.
    initial
    begin : request_side
        cmd_t directed [$];
        mix_t mix;
        int   segment;
        int   n;
        rst_n         <= 1'b0;
        cmd_valid     <= 1'b0;
        cmd           <= '0;
        request_index <= 0;

        // Empty-list failures, inserts at both ends and beyond, reads, updates, deletes.
        directed.push_back(make_cmd(OP_READ,   0,   0));
        directed.push_back(make_cmd(OP_DELETE, 0,   0));
        directed.push_back(make_cmd(OP_UPDATE, 0,   32'h1234_5678));
        directed.push_back(make_cmd(OP_INSERT, 1,   7));
        directed.push_back(make_cmd(OP_INSERT, 0,   32'h8000_0000));
        directed.push_back(make_cmd(OP_INSERT, 1,   32'h7fff_ffff));
        directed.push_back(make_cmd(OP_INSERT, 0,   -1));
        directed.push_back(make_cmd(OP_INSERT, 255, -1));
        directed.push_back(make_cmd(OP_INSERT, 3,   0));
        directed.push_back(make_cmd(OP_READ,   0,   -1));
        directed.push_back(make_cmd(OP_READ,   1,   0));
        directed.push_back(make_cmd(OP_READ,   2,   0));
        directed.push_back(make_cmd(OP_READ,   3,   0));
        directed.push_back(make_cmd(OP_READ,   4,   0));
        directed.push_back(make_cmd(OP_READ,   255, 0));
        directed.push_back(make_cmd(OP_UPDATE, 1,   32'h5555_5555));
        directed.push_back(make_cmd(OP_UPDATE, 255, 32'haaaa_aaaa));
        directed.push_back(make_cmd(OP_READ,   1,   0));
        directed.push_back(make_cmd(OP_DELETE, 4,   0));
        directed.push_back(make_cmd(OP_DELETE, 255, 0));
        directed.push_back(make_cmd(OP_DELETE, 1,   0));
        directed.push_back(make_cmd(OP_DELETE, 2,   0));
        directed.push_back(make_cmd(OP_DELETE, 0,   0));
        directed.push_back(make_cmd(OP_DELETE, 0,   0));
        directed.push_back(make_cmd(OP_READ,   0,   0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[k])
            send_request(directed[k]);
        wait_for_drain();

        // Segments: grow to full, mixed, shrink to empty, mixed, grow again.
        for (n = 0; n < RANDOM_TOTAL; n++)
        begin
            segment = n / SEGMENT_LEN;
            mix = (segment == 0 || segment == 4) ? MIX_GROW :
                  (segment == 2) ? MIX_SHRINK : MIX_EVEN;
            send_request(random_request(mix));
            if (n == DRAIN_POINT)
                wait_for_drain();
            else if (n < RANDOM_TOTAL - QUIET_TAIL && !hold_off && (n < 540 || n >= 620)
                     && $urandom_range(0, 5) == 0)
                idle_sender($urandom_range(1, 13));
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Result side: random stall bursts, one long hold-off to back the block up,
    // and no stalls at the end of the run.
    initial
    begin : result_side
        bit held;
        res_stall <= 1'b0;
        hold_off  <= 1'b0;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (request_index >= REQUEST_TOTAL - QUIET_TAIL)
            begin
                res_stall <= 1'b0;
                @(posedge clk);
            end
            else if (!held && request_index >= HOLD_OFF_START)
            begin
                held = 1'b1;
                hold_off  <= 1'b1;
                res_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off  <= 1'b0;
                res_stall <= 1'b0;
                @(posedge clk);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                res_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                res_stall <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    // Watchdog: ends the run when neither channel moves for too long.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

endmodule
